FILE: design/pfc_pkg.sv
package pfc_pkg;

    // square geometry and letter coding
    localparam int NumRows    = 5;
    localparam int NumCols    = 5;
    localparam int LetterW    = 5;
    localparam int IdxW       = 3;
    localparam int RowW       = NumCols * LetterW;
    localparam int CfgAddrW   = 3;
    localparam int DataW      = 16;
    localparam int InUserW    = 1;
    localparam int OutUserW   = 1;

    typedef logic [LetterW-1:0]                            letter_t;
    typedef logic [IdxW-1:0]                               idx_t;
    typedef logic [RowW-1:0]                               key_row_t;
    typedef logic [NumRows-1:0][NumCols-1:0][LetterW-1:0]  square_t;

    // configuration register indexes
    typedef enum logic [CfgAddrW-1:0] {
        REG_KEY_ROW0 = 3'd0,
        REG_KEY_ROW1 = 3'd1,
        REG_KEY_ROW2 = 3'd2,
        REG_KEY_ROW3 = 3'd3,
        REG_KEY_ROW4 = 3'd4
    } cfg_reg_t;

    // reset square: P J S A B / C D F E T / Y X W V U / Z G H K L / I R O M N
    localparam key_row_t KeyRow0Rst = 25'd1067311;
    localparam key_row_t KeyRow1Rst = 25'd20059234;
    localparam key_row_t KeyRow2Rst = 25'd21682936;
    localparam key_row_t KeyRow3Rst = 25'd11869401;
    localparam key_row_t KeyRow4Rst = 25'd14039592;

    localparam idx_t LastIdx = idx_t'(NumRows - 1);

    // mode encoding on the input tuser bit
    localparam logic ModeEncrypt = 1'b0;
    localparam logic ModeDecrypt = 1'b1;

    // position of a letter in the square
    typedef struct packed {
        logic found;
        idx_t row;
        idx_t col;
    } pfc_pos_t;

    // one step around the square, forward on encrypt, backward on decrypt
    function automatic idx_t step_idx(input idx_t idx, input logic mode);
        idx_t res;
        if (mode == ModeDecrypt) begin
            res = (idx == '0) ? LastIdx : idx - idx_t'(1);
        end else begin
            res = (idx == LastIdx) ? '0 : idx + idx_t'(1);
        end
        return res;
    endfunction

endpackage

FILE: design/pfc_locate.sv
module pfc_locate (
    input  pfc_pkg::square_t  square,
    input  pfc_pkg::letter_t  letter,
    output pfc_pkg::pfc_pos_t pos
);
    import pfc_pkg::*;

    // parallel compare against all cells, first match in row-major order wins
    always_comb begin
        pos = '0;
        for (int r = NumRows - 1; r >= 0; r--) begin
            for (int c = NumCols - 1; c >= 0; c--) begin
                if (square[r][c] == letter) begin
                    pos.found = 1'b1;
                    pos.row   = idx_t'(r);
                    pos.col   = idx_t'(c);
                end
            end
        end
    end

endmodule

FILE: design/playfair_digraph_cipher.sv
// playfair digraph cipher over a 5x5 key square held in five config rows
// an input beat goes into the input register, then the result register; the lookup and shift lie between
// throughput: one pair per cycle while the result channel does not stall
// reset: aresetn synchronous active low; clears both stage valids and loads the
// default key square into the five row registers
module playfair_digraph_cipher (
    input  logic                         aclk,
    input  logic                         aresetn,
    // config write port
    input  logic                         cfg_wr_en,
    input  logic [pfc_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [pfc_pkg::RowW-1:0]     cfg_wr_data,
    // input channel
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pfc_pkg::DataW-1:0]    s_axis_tdata,   // first_letter[4:0], second_letter[9:5]
    input  logic [pfc_pkg::InUserW-1:0]  s_axis_tuser,   // mode[0]
    // result channel
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pfc_pkg::DataW-1:0]    m_axis_tdata,   // out_first[4:0], out_second[9:5]
    output logic [pfc_pkg::OutUserW-1:0] m_axis_tuser    // not_in_square[0]
);
    import pfc_pkg::*;

    square_t  key_reg;

    logic     in_valid_reg;
    logic     in_mode_reg;
    letter_t  in_first_reg;
    letter_t  in_second_reg;

    logic     out_valid_reg;
    letter_t  out_first_reg;
    letter_t  out_second_reg;
    logic     out_miss_reg;

    logic     out_adv;
    logic     in_adv;

    pfc_pos_t pos_a;
    pfc_pos_t pos_b;
    letter_t  out_first_next;
    letter_t  out_second_next;
    logic     out_miss_next;

    // stage flow control
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign in_adv        = !in_valid_reg || out_adv;
    assign s_axis_tready = in_adv;

    // key square rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0] <= KeyRow0Rst;
            key_reg[1] <= KeyRow1Rst;
            key_reg[2] <= KeyRow2Rst;
            key_reg[3] <= KeyRow3Rst;
            key_reg[4] <= KeyRow4Rst;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KEY_ROW0: key_reg[0] <= cfg_wr_data;
                REG_KEY_ROW1: key_reg[1] <= cfg_wr_data;
                REG_KEY_ROW2: key_reg[2] <= cfg_wr_data;
                REG_KEY_ROW3: key_reg[3] <= cfg_wr_data;
                REG_KEY_ROW4: key_reg[4] <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_axis_tvalid) begin
            in_mode_reg   <= s_axis_tuser[0];
            in_first_reg  <= s_axis_tdata[LetterW-1:0];
            in_second_reg <= s_axis_tdata[2*LetterW-1:LetterW];
        end
    end

    // locate both letters
    pfc_locate u_locate_a (
        .square (key_reg),
        .letter (in_first_reg),
        .pos    (pos_a)
    );

    pfc_locate u_locate_b (
        .square (key_reg),
        .letter (in_second_reg),
        .pos    (pos_b)
    );

    // playfair rules: same row, same column, rectangle; a miss flag when a letter is not in the square
    always_comb begin
        out_first_next  = '0;
        out_second_next = '0;
        out_miss_next   = 1'b0;
        priority if (!pos_a.found || !pos_b.found) begin
            out_miss_next = 1'b1;
        end else if (pos_a.row == pos_b.row) begin
            out_first_next  = key_reg[pos_a.row][step_idx(pos_a.col, in_mode_reg)];
            out_second_next = key_reg[pos_b.row][step_idx(pos_b.col, in_mode_reg)];
        end else if (pos_a.col == pos_b.col) begin
            out_first_next  = key_reg[step_idx(pos_a.row, in_mode_reg)][pos_a.col];
            out_second_next = key_reg[step_idx(pos_b.row, in_mode_reg)][pos_b.col];
        end else begin
            out_first_next  = key_reg[pos_a.row][pos_b.col];
            out_second_next = key_reg[pos_b.row][pos_a.col];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && in_valid_reg) begin
            out_first_reg  <= out_first_next;
            out_second_reg <= out_second_next;
            out_miss_reg   <= out_miss_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(DataW - 2*LetterW)'(0), out_second_reg, out_first_reg};
    assign m_axis_tuser  = out_miss_reg;

    // a pending pair moves into the result register whenever that register frees up
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_adv |=> out_valid_reg)
        else $error("pending pair not moved to result register");

    // a full pipe with a stalled result must not take another beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while both stages are full");

    // a missing letter gives zero letters
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[2*LetterW-1:0] == '0)
        else $error("letters not zero on a missing letter");

    // reset empties the result stage
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule
